// ===== hw/rtl/rmsos_pkg.sv =====
// Shared types and fixed constants for the RMS onset segmenter.
// Used by rmsos_root and rms_onset_segmenter_top; depends on nothing.
`default_nettype none

package rmsos_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RMS_W       = 16;
    localparam int MIN_SEG_W   = 20;
    localparam int FLOOR_W     = 15;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int SQ_W        = 32;
    localparam int ROOT_IN_W   = 32;
    localparam int ROOT_STEPS  = 16;
    localparam int SQRT_CNT_W  = 4;
    localparam int SREM_W      = 18;

    localparam logic [MIN_SEG_W-1:0] MIN_SEG_RESET = 20'd11025;
    localparam logic [FLOOR_W-1:0]   FLOOR_RESET   = 15'd328;
    localparam logic [MIN_SEG_W-1:0] SEG_MAX       = 20'hFFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SEG = 1'b0,
        CFG_FLOOR   = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmsos_root.sv =====
// Frame RMS unit: restoring divider (sum / n, one quotient bit a cycle)
// followed by a digit-by-digit square root (one result bit a cycle). Uses rmsos_pkg.
`default_nettype none

module rmsos_root #(
    parameter int SUM_W = 41,
    parameter int CNT_W = 11
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [SUM_W-1:0]            sum,
    input  wire logic [CNT_W-1:0]            n,
    output logic                             done,
    output logic [rmsos_pkg::RMS_W-1:0]      rms
);

    localparam int DCNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_DIV  = 3'b010,
        R_SQRT = 3'b100
    } rstate_t;

    rstate_t                              state_reg;
    logic [DCNT_W-1:0]                    dcnt_reg;
    logic [rmsos_pkg::SQRT_CNT_W-1:0]     scnt_reg;
    logic                                 done_reg;
    logic [SUM_W-1:0]                     quo_reg;
    logic [CNT_W-1:0]                     rem_reg;
    logic [CNT_W-1:0]                     n_reg;
    logic [rmsos_pkg::ROOT_IN_W-1:0]      v_reg;
    logic [rmsos_pkg::SREM_W-1:0]         srem_reg;
    logic [rmsos_pkg::RMS_W-1:0]          root_reg;

    logic [CNT_W:0]                       trial;
    logic [CNT_W:0]                       trial_diff;
    logic                                 div_ge;
    logic [SUM_W-1:0]                     quo_step;
    logic [CNT_W-1:0]                     rem_step;
    logic [rmsos_pkg::SREM_W-1:0]         srem_sh;
    logic [rmsos_pkg::SREM_W-1:0]         strial;
    logic                                 sq_ge;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[SUM_W-1]};
        trial_diff = trial - {1'b0, n_reg};
        div_ge     = (trial >= {1'b0, n_reg});
        quo_step   = {quo_reg[SUM_W-2:0], div_ge};
        rem_step   = div_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
        srem_sh    = {srem_reg[rmsos_pkg::SREM_W-3:0],
                      v_reg[rmsos_pkg::ROOT_IN_W-1 -: 2]};
        strial     = {root_reg, 2'b01};
        sq_ge      = (srem_sh >= strial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            dcnt_reg  <= '0;
            scnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_DIV;
                        dcnt_reg  <= DCNT_W'(SUM_W - 1);
                    end
                end
                R_DIV:
                begin
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= R_SQRT;
                        scnt_reg  <= rmsos_pkg::SQRT_CNT_W'(rmsos_pkg::ROOT_STEPS - 1);
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end
                end
                R_SQRT:
                begin
                    if (scnt_reg == '0)
                    begin
                        state_reg <= R_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        scnt_reg <= scnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    quo_reg <= sum;
                    rem_reg <= '0;
                    n_reg   <= n;
                end
            end
            R_DIV:
            begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                if (dcnt_reg == '0)
                begin
                    // quotient never exceeds 2^30, so the low bits carry it all
                    v_reg    <= rmsos_pkg::ROOT_IN_W'(quo_step);
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            R_SQRT:
            begin
                v_reg    <= {v_reg[rmsos_pkg::ROOT_IN_W-3:0], 2'b00};
                srem_reg <= sq_ge ? (srem_sh - strial) : srem_sh;
                root_reg <= {root_reg[rmsos_pkg::RMS_W-2:0], sq_ge};
            end
            default:
            begin
                quo_reg <= quo_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign rms  = root_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rmsos_mul.sv =====
// Shift-add multiplier, one multiplier bit a cycle, shared by the history statistics.
// Standalone; no package use.
`default_nettype none

module rmsos_mul #(
    parameter int MC_W = 37,
    parameter int ML_W = 22
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [MC_W-1:0]         mcand,
    input  wire logic [ML_W-1:0]         mplier,
    output logic                         done,
    output logic [MC_W+ML_W-1:0]         product
);

    localparam int P_W   = MC_W + ML_W;
    localparam int CNT_W = $clog2(ML_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [P_W-1:0]      acc_reg;
    logic [P_W-1:0]      mc_reg;
    logic [ML_W-1:0]     ml_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ML_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mc_reg  <= P_W'(mcand);
            ml_reg  <= mplier;
        end
        else if (busy_reg)
        begin
            if (ml_reg[0])
            begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= {mc_reg[P_W-2:0], 1'b0};
            ml_reg <= {1'b0, ml_reg[ML_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rms_onset_segmenter_top.sv =====
// RMS onset segmenter top level: sample accumulation, history memory, statistics.
// Depends on rmsos_pkg, rmsos_root and rmsos_mul.
//
// Each accepted sample is captured, squared and accumulated; in_stall is high while
// it is squared and accumulated. A sample that ends a frame then holds the input for
// the frame computation: SUM_W division steps (SUM_W = clog2(MAX_FRAME+1) + 30), 16
// square root steps, three passes of the shift-add multiplier of T_W =
// clog2(HISTORY_DEPTH) + 16 steps each, and the control and history update states.
// One result (onset, frame_rms) is given per frame end and held in an output
// register; the block waits for it to be taken only if a new frame result is
// ready before the old one leaves. The RMS history sits in a single-port
// synchronous memory with per-entry valid bits, so no clearing pass is needed
// after reset. Configuration writes are always accepted.
`default_nettype none

module rms_onset_segmenter_top #(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_FRAME     = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [rmsos_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic                                    last_in_frame,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic                                         onset,
    output logic [rmsos_pkg::RMS_W-1:0]                  frame_rms,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [rmsos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rmsos_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = CNT_W + 30;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int T_W   = PTR_W + 16;
    localparam int Q_W   = PTR_W + 31;
    localparam int P_W   = Q_W + T_W;
    localparam int V_W   = P_W + 2;
    localparam int RMS_W = rmsos_pkg::RMS_W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SQ   = 12'b0000_0000_0010,
        S_ACC  = 12'b0000_0000_0100,
        S_ROOT = 12'b0000_0000_1000,
        S_STAT = 12'b0000_0001_0000,
        S_MDQ  = 12'b0000_0010_0000,
        S_MTT  = 12'b0000_0100_0000,
        S_MAA  = 12'b0000_1000_0000,
        S_OSQ  = 12'b0001_0000_0000,
        S_RSQ  = 12'b0010_0000_0000,
        S_UPD  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } state_t;

    // configuration
    logic [rmsos_pkg::MIN_SEG_W-1:0]  min_seg_reg;
    logic [rmsos_pkg::FLOOR_W-1:0]    floor_reg;

    // control state
    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        frame_count_reg;
    logic [SUM_W-1:0]        square_sum_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [T_W-1:0]          t_reg;
    logic [Q_W-1:0]          q_reg;
    logic [rmsos_pkg::MIN_SEG_W-1:0] seg_reg;
    logic [HISTORY_DEPTH-1:0] hvalid_reg;
    logic                    out_valid_reg;

    // datapath
    logic [RMS_W-1:0]        mag_reg;
    logic                    last_reg;
    logic                    ok_reg;
    logic [rmsos_pkg::SQ_W-1:0] prod16_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [RMS_W-1:0]        rms_reg;
    logic                    gt_reg;
    logic [T_W-1:0]          a_reg;
    logic [P_W-1:0]          dq_reg;
    logic [V_W-1:0]          var4_reg;
    logic                    onset_reg;
    logic                    onset_out_reg;
    logic [RMS_W-1:0]        rms_out_reg;

    // history memory
    logic [RMS_W-1:0]        hist_mem [HISTORY_DEPTH];
    logic [RMS_W-1:0]        rd_data_reg;
    logic                    rd_valid_reg;

    logic                    in_accept;
    logic                    out_take;
    logic [RMS_W-1:0]        mag;
    logic [SUM_W-1:0]        sum_upd;
    logic [CNT_W-1:0]        cnt_upd;
    logic [RMS_W-1:0]        old_rms;
    logic [RMS_W-1:0]        sq_op;
    logic [T_W-1:0]          d_rms;
    logic [rmsos_pkg::MIN_SEG_W-1:0] seg_base;
    logic [rmsos_pkg::MIN_SEG_W:0]   seg_sum;
    logic                    hist_rd;
    logic                    hist_wr;

    logic                    root_start;
    logic                    root_done;
    logic [RMS_W-1:0]        root_rms;
    logic                    mul_start;
    logic [Q_W-1:0]          mul_mcand;
    logic [T_W-1:0]          mul_mplier;
    logic                    mul_done;
    logic [P_W-1:0]          mul_product;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mag      = sample[rmsos_pkg::SAMPLE_W-1] ? (~sample + 16'd1) : sample;
        sum_upd  = square_sum_reg + (ok_reg ? SUM_W'(prod16_reg) : SUM_W'(0));
        cnt_upd  = frame_count_reg + (ok_reg ? CNT_W'(1) : CNT_W'(0));
        old_rms  = rd_valid_reg ? rd_data_reg : '0;
        d_rms    = T_W'(rms_reg) * T_W'(HISTORY_DEPTH);
        seg_base = onset_reg ? '0 : seg_reg;
        seg_sum  = {1'b0, seg_base} + (rmsos_pkg::MIN_SEG_W + 1)'(n_reg);
        hist_rd  = (state_reg == S_ACC) && last_reg;
        hist_wr  = (state_reg == S_UPD);
        root_start = hist_rd;
        case (state_reg)
            S_OSQ:   sq_op = old_rms;
            S_RSQ:   sq_op = rms_reg;
            default: sq_op = mag_reg;
        endcase
    end

    // shared multiplier requests: D*Q, then T*T, then a*a
    always_comb
    begin
        mul_start  = 1'b0;
        mul_mcand  = q_reg;
        mul_mplier = T_W'(HISTORY_DEPTH);
        case (state_reg)
            S_STAT:
            begin
                mul_start = 1'b1;
            end
            S_MDQ:
            begin
                mul_start  = mul_done;
                mul_mcand  = Q_W'(t_reg);
                mul_mplier = t_reg;
            end
            S_MTT:
            begin
                mul_start  = mul_done;
                mul_mcand  = Q_W'(a_reg);
                mul_mplier = a_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_accept) state_next = S_SQ;
            S_SQ:   state_next = S_ACC;
            S_ACC:  state_next = last_reg ? S_ROOT : S_IDLE;
            S_ROOT: if (root_done) state_next = S_STAT;
            S_STAT: state_next = S_MDQ;
            S_MDQ:  if (mul_done) state_next = S_MTT;
            S_MTT:  if (mul_done) state_next = S_MAA;
            S_MAA:  if (mul_done) state_next = S_OSQ;
            S_OSQ:  state_next = S_RSQ;
            S_RSQ:  state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:  if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_seg_reg <= rmsos_pkg::MIN_SEG_RESET;
            floor_reg   <= rmsos_pkg::FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rmsos_pkg::cfg_idx_t'(cfg_index))
                rmsos_pkg::CFG_MIN_SEG: min_seg_reg <= cfg_data;
                rmsos_pkg::CFG_FLOOR:   floor_reg   <= cfg_data[rmsos_pkg::FLOOR_W-1:0];
                default:                floor_reg   <= floor_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            frame_count_reg <= '0;
            square_sum_reg  <= '0;
            ptr_reg         <= '0;
            t_reg           <= '0;
            q_reg           <= '0;
            seg_reg         <= '0;
            hvalid_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                if (last_reg)
                begin
                    square_sum_reg  <= '0;
                    frame_count_reg <= '0;
                end
                else
                begin
                    square_sum_reg  <= sum_upd;
                    frame_count_reg <= cnt_upd;
                end
            end
            // drop the oldest square first, then add the new one in the update state
            if (state_reg == S_RSQ)
            begin
                q_reg <= q_reg - Q_W'(prod16_reg);
            end
            if (state_reg == S_UPD)
            begin
                q_reg   <= q_reg + Q_W'(prod16_reg);
                t_reg   <= t_reg - T_W'(old_rms) + T_W'(rms_reg);
                seg_reg <= (seg_sum > {1'b0, rmsos_pkg::SEG_MAX}) ?
                           rmsos_pkg::SEG_MAX : seg_sum[rmsos_pkg::MIN_SEG_W-1:0];
                hvalid_reg[ptr_reg] <= 1'b1;
                ptr_reg <= (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            end
            if ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_reg  <= mag;
            last_reg <= last_in_frame;
            ok_reg   <= (frame_count_reg < CNT_W'(MAX_FRAME));
        end
        if ((state_reg == S_SQ) || (state_reg == S_OSQ) || (state_reg == S_RSQ))
        begin
            prod16_reg <= sq_op * sq_op;
        end
        if (hist_rd)
        begin
            n_reg <= cnt_upd;
        end
        if ((state_reg == S_ROOT) && root_done)
        begin
            rms_reg <= root_rms;
        end
        if (state_reg == S_STAT)
        begin
            gt_reg <= (d_rms > t_reg);
            a_reg  <= d_rms - t_reg;
        end
        if ((state_reg == S_MDQ) && mul_done)
        begin
            dq_reg <= mul_product;
        end
        if ((state_reg == S_MTT) && mul_done)
        begin
            var4_reg <= {dq_reg - mul_product, 2'b00};
        end
        if ((state_reg == S_MAA) && mul_done)
        begin
            onset_reg <= gt_reg && ({2'b00, mul_product} > var4_reg)
                         && (rms_reg > {1'b0, floor_reg}) && (seg_reg > min_seg_reg);
        end
        if ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
        begin
            onset_out_reg <= onset_reg;
            rms_out_reg   <= rms_reg;
        end
    end

    // history memory: read the slot being replaced at frame end, write the new frame RMS into it later
    always_ff @(posedge clk)
    begin
        if (hist_wr)
        begin
            hist_mem[ptr_reg] <= rms_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_rd)
        begin
            rd_data_reg  <= hist_mem[ptr_reg];
            rd_valid_reg <= hvalid_reg[ptr_reg];
        end
    end

    rmsos_root #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .sum   (sum_upd),
        .n     (cnt_upd),
        .done  (root_done),
        .rms   (root_rms)
    );

    rmsos_mul #(
        .MC_W (Q_W),
        .ML_W (T_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_product)
    );

    assign out_valid = out_valid_reg;
    assign onset     = onset_out_reg;
    assign frame_rms = rms_out_reg;

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown outside the output state");

    a_frame_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= CNT_W'(MAX_FRAME))
        else $error("frame count beyond the frame limit");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MDQ || state_reg == S_MTT || state_reg == S_MAA))
        else $error("multiplier finished outside a statistics state");

    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == S_ROOT))
        else $error("root unit finished outside the root state");

    a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        root_start |=> (state_reg == S_ROOT) && !mul_done)
        else $error("frame end did not hand over to the root unit");

endmodule

`default_nettype wire
